// ----- design/lzss_split_flag_decompress_top_defines.svh -----
// Assertion macros used by the decompressor's sequencer (lzss_ctrl).
`ifndef LZSS_SPLIT_FLAG_DECOMPRESS_TOP_DEFINES_SVH
`define LZSS_SPLIT_FLAG_DECOMPRESS_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LZSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzss same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LZSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzss next-cycle check failed");

`endif

// ----- design/lzss_pkg.sv -----
// Shared constants and types of the LZSS split-flag decompressor.
package lzss_pkg;

   // History ring size and the widths that follow from it.
   localparam int WINDOW_SIZE = 4096;
   localparam int HIST_AW     = $clog2(WINDOW_SIZE);

   // Token layout and stream counter widths.
   localparam int LEN_W       = 24;
   localparam int DIST_W      = 12;
   localparam int MLEN_W      = 4;
   localparam int MLEN_LSB    = 12;
   localparam int MIN_MATCH   = 3;
   localparam int REM_W       = 5;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EMIT = 4'b0100,
      ST_ERR  = 4'b1000
   } state_type;

   // Access request from the sequencer to the history memory.
   typedef struct packed {
      logic               we;
      logic [HIST_AW-1:0] waddr;
      logic [7:0]         wdata;
      logic               re;
      logic [HIST_AW-1:0] raddr;
   } ram_req_type;

endpackage

// ----- design/lzss_if.sv -----
// Valid/ready channel interfaces for tokens, output bytes and the length register.

interface lzss_req_if
   import lzss_pkg::*;
();
   logic        valid;
   logic        ready;
   logic        first;
   logic        backref;
   logic [15:0] token_word;

   modport source (output valid, first, backref, token_word, input ready);
   modport sink   (input valid, first, backref, token_word, output ready);
endinterface

interface lzss_rsp_if
   import lzss_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;
   logic       error;

   modport source (output valid, data_byte, last, error, input ready);
   modport sink   (input valid, data_byte, last, error, output ready);
endinterface

interface lzss_csr_if
   import lzss_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- design/lzss_split_flag_decompress_top.sv -----
// Top level of the LZSS split-flag decompressor with a 4 KiB history ring.
// A literal or an error token moves the sequencer to ST_EMIT or ST_ERR, which loads the output register.
// A match copies byte by byte: each byte needs a history read (ST_READ) and then a write-back (ST_EMIT).
// A token that gives no result leaves the sequencer in ST_IDLE; a stalled consumer holds the copy loop.
// Reset clears the counters, the finished flag, out_length and the output valid flag.
// The history memory is not cleared; the distance check keeps reads within written bytes.
module lzss_split_flag_decompress_top
   import lzss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lzss_req_if.sink   req_ch,
   lzss_rsp_if.source rsp_ch,
   lzss_csr_if.sink   csr_ch
);

   logic [LEN_W-1:0] out_length_ff;
   ram_req_type      ram_req;
   logic [7:0]       rd_data;

   // Length register; a write transfer is always taken.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_length_ff <= '0;
      end else if (csr_ch.valid) begin
         out_length_ff <= csr_ch.data;
      end
   end

   // Sequencer.
   lzss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .out_length (out_length_ff),
      .rd_data    (rd_data),
      .ram_req    (ram_req)
   );

   // History ring.
   lzss_hist_ram u_hist (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule

// ----- design/lzss_hist_ram.sv -----
// History ring memory: one write port and one registered read port.
module lzss_hist_ram
   import lzss_pkg::*;
(
   input  logic        clock,
   input  ram_req_type ram_req,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [WINDOW_SIZE];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         rd_data_ff <= mem[ram_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lzss_ctrl.sv -----
// Token sequencer: stream counters, match copy loop and the output register.
`include "lzss_split_flag_decompress_top_defines.svh"

module lzss_ctrl
   import lzss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   lzss_req_if.sink         req_ch,
   lzss_rsp_if.source       rsp_ch,
   input  logic [LEN_W-1:0] out_length,
   input  logic [7:0]       rd_data,
   output ram_req_type      ram_req
);

   state_type          state_ff, state_in;
   logic [HIST_AW-1:0] wp_ff, wp_in;
   logic [LEN_W-1:0]   pc_ff, pc_in;
   logic               fin_ff, fin_in;
   logic               lit_mode_ff, lit_mode_in;
   logic [7:0]         lit_ff, lit_in;
   logic [DIST_W-1:0]  dist_m1_ff, dist_m1_in;
   logic [REM_W-1:0]   remain_ff, remain_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_err_ff, rsp_err_in;

   logic               out_free;
   logic               accept;
   logic [HIST_AW-1:0] wp_eff;
   logic [LEN_W-1:0]   pc_eff;
   logic               fin_eff;
   logic               dist_bad;
   logic [LEN_W-1:0]   pc_inc;
   logic               is_last;
   logic [7:0]         emit_byte;

   // Handshake and the counter values as seen by the incoming token.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign wp_eff       = req_ch.first ? '0 : wp_ff;
   assign pc_eff       = req_ch.first ? '0 : pc_ff;
   assign fin_eff      = req_ch.first ? 1'b0 : fin_ff;

   // A distance of d+1 is out of reach when d is at least the byte count.
   assign dist_bad  = (LEN_W'(req_ch.token_word[DIST_W-1:0]) >= pc_eff);
   assign pc_inc    = pc_ff + LEN_W'(1);
   assign is_last   = (pc_inc >= out_length);
   assign emit_byte = lit_mode_ff ? lit_ff : rd_data;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      pc_in        = pc_ff;
      fin_in       = fin_ff;
      lit_mode_in  = lit_mode_ff;
      lit_in       = lit_ff;
      dist_m1_in   = dist_m1_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      ram_req      = '0;
      ram_req.waddr = wp_ff;
      ram_req.wdata = emit_byte;
      ram_req.raddr = wp_ff - HIST_AW'(dist_m1_ff) - HIST_AW'(1);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wp_in  = wp_eff;
               pc_in  = pc_eff;
               fin_in = fin_eff;
               if (!fin_eff) begin
                  if (pc_eff >= out_length) begin
                     fin_in = 1'b1;
                  end else if (!req_ch.backref) begin
                     lit_mode_in = 1'b1;
                     lit_in      = req_ch.token_word[7:0];
                     state_in    = ST_EMIT;
                  end else if (dist_bad) begin
                     fin_in   = 1'b1;
                     state_in = ST_ERR;
                  end else begin
                     lit_mode_in = 1'b0;
                     dist_m1_in  = req_ch.token_word[DIST_W-1:0];
                     remain_in   = REM_W'(req_ch.token_word[MLEN_LSB +: MLEN_W])
                                   + REM_W'(MIN_MATCH);
                     state_in    = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            // Fetch the source byte; it is written back in ST_EMIT, once the output register is free.
            ram_req.re = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               ram_req.we   = 1'b1;
               wp_in        = wp_ff + HIST_AW'(1);
               pc_in        = pc_inc;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = emit_byte;
               rsp_last_in  = is_last;
               rsp_err_in   = 1'b0;
               if (is_last) begin
                  fin_in = 1'b1;
               end
               if (lit_mode_ff || is_last || (remain_ff == REM_W'(1))) begin
                  state_in = ST_IDLE;
               end else begin
                  remain_in = remain_ff - REM_W'(1);
                  state_in  = ST_READ;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = 8'h00;
               rsp_last_in  = 1'b1;
               rsp_err_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         pc_ff        <= '0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         pc_ff        <= pc_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Token and output payload registers.
   always_ff @(posedge clock) begin
      lit_mode_ff <= lit_mode_in;
      lit_ff      <= lit_in;
      dist_m1_ff  <= dist_m1_in;
      remain_ff   <= remain_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.data_byte = rsp_byte_ff;
   assign rsp_ch.last      = rsp_last_ff;
   assign rsp_ch.error     = rsp_err_ff;

   // A byte is written only when it is also handed to the output register.
   `LZSS_ASSERT_IMPL(a_we_emit, clock, reset, ram_req.we, (state_ff == ST_EMIT) && out_free)
   // Reads and writes to the history never share a cycle.
   `LZSS_ASSERT_IMPL(a_rw_excl, clock, reset, ram_req.we, !ram_req.re)
   // Every fetch is followed by the cycle that consumes it.
   `LZSS_ASSERT_NEXT(a_read_emit, clock, reset, state_ff == ST_READ, state_ff == ST_EMIT)
   // A copy in progress always has bytes left to produce.
   `LZSS_ASSERT_IMPL(a_remain, clock, reset, state_ff == ST_READ, remain_ff != '0)

endmodule

// ----- bench/tb_lzss_split_flag_decompress_top.sv -----
// Self-checking testbench for the LZSS split-flag decompressor top level.
module tb_lzss_split_flag_decompress_top;
   import lzss_pkg::*;

   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 100;
   localparam int SHORT_ITEMS  = 40;
   localparam int LONG_BYTES   = 4400;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // How a token's results are known: from the predictor, or typed into the table.
   typedef enum logic [1:0] {
      EXP_PREDICT,
      EXP_NONE,
      EXP_ONE
   } exp_kind_type;

   typedef enum logic {
      ROW_TOKEN,
      ROW_CFG
   } row_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic       error;
   } out_byte_type;

   typedef struct packed {
      exp_kind_type check;
      out_byte_type value;
   } typed_exp_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [LEN_W-1:0] length;
      logic             first;
      logic             backref;
      logic [15:0]      word;
      exp_kind_type     check;
      out_byte_type     value;
   } stim_row_type;

   // Directed stimulus: length register writes and tokens, in order.
   localparam stim_row_type DIRECTED_ROWS [30] = '{
      // Length still zero from reset: the token is dropped.
      '{ROW_TOKEN, 24'd0, 1'b1, 1'b0, 16'h1234, EXP_NONE, '{8'h00, 1'b0, 1'b0}},
      '{ROW_CFG, 24'd5, 1'b0, 1'b0, 16'h0000, EXP_NONE, '{8'h00, 1'b0, 1'b0}},
      // Literal upper bits ignored, then a distance beyond the output so far.
      '{ROW_TOKEN, 24'd0, 1'b1, 1'b0, 16'hFF00, EXP_ONE, '{8'h00, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b0, 16'h00FF, EXP_ONE, '{8'hFF, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b1, 16'h0002, EXP_ONE, '{8'h00, 1'b1, 1'b1}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b0, 16'h0077, EXP_NONE, '{8'h00, 1'b0, 1'b0}},
      // Overlapping copy that lands exactly on the length.
      '{ROW_TOKEN, 24'd0, 1'b1, 1'b0, 16'h00A5, EXP_ONE, '{8'hA5, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b0, 16'h005A, EXP_ONE, '{8'h5A, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b1, 16'h0000, EXP_PREDICT, '{8'h00, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b0, 16'h0001, EXP_NONE, '{8'h00, 1'b0, 1'b0}},
      '{ROW_CFG, 24'd10, 1'b0, 1'b0, 16'h0000, EXP_NONE, '{8'h00, 1'b0, 1'b0}},
      // Longest match cut short by the length.
      '{ROW_TOKEN, 24'd0, 1'b1, 1'b0, 16'h0011, EXP_ONE, '{8'h11, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b0, 16'h0022, EXP_ONE, '{8'h22, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b1, 16'hF001, EXP_PREDICT, '{8'h00, 1'b0, 1'b0}},
      '{ROW_CFG, LEN_MAX, 1'b0, 1'b0, 16'h0000, EXP_NONE, '{8'h00, 1'b0, 1'b0}},
      // Largest distance on an empty stream, then extreme match lengths.
      '{ROW_TOKEN, 24'd0, 1'b1, 1'b1, 16'hFFFF, EXP_ONE, '{8'h00, 1'b1, 1'b1}},
      '{ROW_TOKEN, 24'd0, 1'b1, 1'b0, 16'h00FF, EXP_ONE, '{8'hFF, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b1, 16'h0000, EXP_PREDICT, '{8'h00, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b1, 16'hF000, EXP_PREDICT, '{8'h00, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b1, 16'h0013, EXP_PREDICT, '{8'h00, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b1, 1'b1, 16'h0000, EXP_ONE, '{8'h00, 1'b1, 1'b1}},
      '{ROW_CFG, 24'd20, 1'b0, 1'b0, 16'h0000, EXP_NONE, '{8'h00, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b1, 1'b0, 16'h0001, EXP_ONE, '{8'h01, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b0, 16'h0002, EXP_ONE, '{8'h02, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b0, 16'h0003, EXP_ONE, '{8'h03, 1'b0, 1'b0}},
      // Length lowered below the output so far: the stream stops silently.
      '{ROW_CFG, 24'd2, 1'b0, 1'b0, 16'h0000, EXP_NONE, '{8'h00, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b0, 16'h0004, EXP_NONE, '{8'h00, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b1, 16'h0000, EXP_NONE, '{8'h00, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b1, 1'b0, 16'h0055, EXP_ONE, '{8'h55, 1'b0, 1'b0}},
      '{ROW_TOKEN, 24'd0, 1'b0, 1'b0, 16'h0066, EXP_ONE, '{8'h66, 1'b1, 1'b0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   lzss_req_if req_ch ();
   lzss_rsp_if rsp_ch ();
   lzss_csr_if csr_ch ();

   lzss_split_flag_decompress_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Decompressor state as the predictor sees it.
   logic [7:0]       history_ring [WINDOW_SIZE];
   logic [HIST_AW-1:0] hist_pos    = '0;
   logic [LEN_W-1:0] bytes_made    = '0;
   logic             stream_done   = 1'b0;
   logic [LEN_W-1:0] out_len       = '0;

   out_byte_type  expected_bytes [$];
   typed_exp_type typed_checks [$];
   int            error_count  = 0;
   int            results_seen = 0;
   bit            sender_calm  = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Appends one byte to the history and to the expected output.
   function automatic void put_byte(input logic [7:0] b, ref out_byte_type res [$]);
      logic done_now;
      history_ring[hist_pos] = b;
      hist_pos   = hist_pos + 1'b1;
      bytes_made = bytes_made + 1'b1;
      done_now   = (bytes_made >= out_len);
      if (done_now) begin
         stream_done = 1'b1;
      end
      res.insert(res.size(), out_byte_type'{b, done_now, 1'b0});
   endfunction

   // Works out the output bytes that one token gives.
   function automatic void decode_token(input logic first, input logic backref,
                                        input logic [15:0] word, ref out_byte_type res [$]);
      logic [4:0]         span;
      logic [DIST_W:0]    back_dist;
      logic [HIST_AW-1:0] src;
      if (first) begin
         hist_pos    = '0;
         bytes_made  = '0;
         stream_done = 1'b0;
      end
      if (stream_done) begin
         return;
      end
      if (bytes_made >= out_len) begin
         stream_done = 1'b1;
         return;
      end
      if (!backref) begin
         put_byte(word[7:0], res);
         return;
      end
      span      = 5'(word[MLEN_LSB +: MLEN_W]) + 5'(MIN_MATCH);
      back_dist = {1'b0, word[DIST_W-1:0]} + 1'b1;
      if (LEN_W'(back_dist) > bytes_made) begin
         stream_done = 1'b1;
         res.insert(res.size(), out_byte_type'{8'h00, 1'b1, 1'b1});
         return;
      end
      // Copy byte by byte so that an overlapping copy repeats what it has just written.
      for (int i = 0; i < span && !stream_done; i++) begin
         src = hist_pos - back_dist[HIST_AW-1:0];
         put_byte(history_ring[src], res);
      end
   endfunction

   task automatic flag_mismatch(input string what);
      error_count++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   function automatic int pick_gap();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   // Watches all three channels: a transfer updates the predictor or is checked.
   always @(posedge clock) begin : watch_channels
      out_byte_type  produced [$];
      typed_exp_type chk;
      out_byte_type  got;
      out_byte_type  want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.data_byte, rsp_ch.last, rsp_ch.error};
            if (expected_bytes.size() == 0) begin
               flag_mismatch($sformatf("byte %0d arrived with nothing expected", results_seen));
            end else begin
               want = expected_bytes.pop_front();
               if (got.data_byte !== want.data_byte) begin
                  flag_mismatch($sformatf("byte %0d: data_byte %02h, expected %02h",
                                          results_seen, got.data_byte, want.data_byte));
               end
               if (got.last !== want.last) begin
                  flag_mismatch($sformatf("byte %0d: last %b, expected %b",
                                          results_seen, got.last, want.last));
               end
               if (got.error !== want.error) begin
                  flag_mismatch($sformatf("byte %0d: error %b, expected %b",
                                          results_seen, got.error, want.error));
               end
            end
            results_seen++;
         end
         if (req_ch.valid && req_ch.ready) begin
            produced.delete();
            decode_token(req_ch.first, req_ch.backref, req_ch.token_word, produced);
            chk = typed_checks.pop_front();
            if (chk.check == EXP_PREDICT) begin
               foreach (produced[i]) begin
                  expected_bytes.insert(expected_bytes.size(), produced[i]);
               end
            end else if (chk.check == EXP_ONE) begin
               expected_bytes.insert(expected_bytes.size(), chk.value);
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            out_len = csr_ch.data;
         end
      end
   end

   // Output back-pressure: random stalls, calm stretches and one long hold-off.
   initial begin : drive_rsp_ready
      int stall_left;
      int hold_left;
      int calm_left;
      bit held;
      stall_left = 0;
      hold_left  = 0;
      calm_left  = 0;
      held       = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (calm_left > 0) begin
            calm_left--;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (!held && results_seen >= HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (calm_left == 0 && $urandom_range(0, 199) == 0) begin
               calm_left = 100;
            end else if (calm_left == 0 && $urandom_range(0, 99) < 15) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   // Offers one token and returns at the edge of its transfer, with valid still high.
   task automatic send_token(input logic first, input logic backref, input logic [15:0] word,
                             input exp_kind_type check, input out_byte_type value);
      int gap;
      gap = (!sender_calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_checks.insert(typed_checks.size(), typed_exp_type'{check, value});
      req_ch.valid      <= 1'b1;
      req_ch.first      <= first;
      req_ch.backref    <= backref;
      req_ch.token_word <= word;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Lets every expected byte arrive, then leaves room for a token that gives none.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_out_length(input logic [LEN_W-1:0] value);
      wait_idle();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // One stream of mostly well-formed tokens, with some noise and the odd bad distance.
   task automatic random_stream(input logic [LEN_W-1:0] limit, input int max_tokens,
                                inout int counted);
      int   made;
      int   cap;
      int   back_dist;
      int   pick;
      bit   over;
      logic restart;
      logic [3:0] code;
      made = 0;
      over = 1'b0;
      write_out_length(limit);
      sender_calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < max_tokens && !over; n++) begin
         pick = $urandom_range(0, 99);
         cap  = (made < WINDOW_SIZE) ? made : WINDOW_SIZE;
         code = 4'($urandom);
         if (n > 0 && pick < 5) begin
            // Noise: any flag and any word, sometimes restarting the stream.
            restart = ($urandom_range(0, 3) == 0);
            send_token(restart, 1'($urandom), 16'($urandom), EXP_PREDICT, '0);
            if (restart) begin
               made = 0;
            end
         end else if (n > 0 && pick < 10 && made < WINDOW_SIZE) begin
            back_dist = $urandom_range(made + 1, WINDOW_SIZE);
            send_token(1'b0, 1'b1, {code, 12'(back_dist - 1)}, EXP_PREDICT, '0);
            over = 1'b1;
         end else if (cap == 0 || pick < 50) begin
            send_token(n == 0, 1'b0, 16'($urandom), EXP_PREDICT, '0);
            made++;
         end else begin
            back_dist = (pick >= 92) ? cap : $urandom_range(1, cap);
            send_token(1'b0, 1'b1, {code, 12'(back_dist - 1)}, EXP_PREDICT, '0);
            made += int'(code) + MIN_MATCH;
         end
         counted++;
         if (made >= limit) begin
            over = 1'b1;
         end
      end
      // Now and then a token after the stream has ended, which must give nothing.
      if (over && $urandom_range(0, 2) == 0) begin
         send_token(1'b0, 1'($urandom), 16'($urandom), EXP_PREDICT, '0);
      end
   endtask

   // A long stream of mostly longest matches, so that the history ring wraps.
   task automatic long_stream();
      int made;
      int cap;
      int back_dist;
      int pick;
      logic [3:0] code;
      write_out_length(LEN_W'($urandom_range(8000, 16777215)));
      sender_calm = 1'b0;
      send_token(1'b1, 1'b0, 16'($urandom), EXP_PREDICT, '0);
      made = 1;
      while (made < LONG_BYTES) begin
         pick = $urandom_range(0, 99);
         cap  = (made < WINDOW_SIZE) ? made : WINDOW_SIZE;
         if (pick < 5) begin
            send_token(1'b0, 1'b0, 16'($urandom), EXP_PREDICT, '0);
            made++;
         end else begin
            code = (pick < 95) ? 4'hF : 4'($urandom);
            back_dist = (pick % 5 == 0) ? cap : $urandom_range(1, cap);
            send_token(1'b0, 1'b1, {code, 12'(back_dist - 1)}, EXP_PREDICT, '0);
            made += int'(code) + MIN_MATCH;
         end
      end
   endtask

   // Main sequence: reset, directed table, random streams, long stream, verdict.
   initial begin : main_sequence
      int short_items;
      int stream_idx;
      logic [LEN_W-1:0] limit;
      short_items = 0;
      stream_idx  = 0;
      req_ch.valid      <= 1'b0;
      req_ch.first      <= 1'b0;
      req_ch.backref    <= 1'b0;
      req_ch.token_word <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.data       <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
            write_out_length(DIRECTED_ROWS[i].length);
         end else begin
            send_token(DIRECTED_ROWS[i].first, DIRECTED_ROWS[i].backref,
                       DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].check,
                       DIRECTED_ROWS[i].value);
         end
      end

      // Mostly short lengths; a zero length at least once and a few large ones.
      while (short_items < SHORT_ITEMS) begin
         pick_limit : begin
            int pick;
            pick = $urandom_range(0, 99);
            if (stream_idx == 0 || pick < 8) begin
               limit = '0;
            end else if (pick < 75) begin
               limit = LEN_W'($urandom_range(1, 40));
            end else if (pick < 90) begin
               limit = LEN_W'($urandom_range(41, 300));
            end else begin
               limit = LEN_W'($urandom);
            end
         end
         random_stream(limit, $urandom_range(3, 30), short_items);
         stream_idx++;
      end

      long_stream();
      wait_idle();

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/lzss_pkg.sv
design/lzss_if.sv
design/lzss_hist_ram.sv
design/lzss_ctrl.sv
design/lzss_split_flag_decompress_top.sv
bench/tb_lzss_split_flag_decompress_top.sv
